// ===== src/masked_byte_pattern_scanner_assert.svh =====
// assertion macros for the masked byte pattern scanner
// expects clk_i and rst_ni in the including module's scope
`ifndef MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH

// same-cycle implication
`define MBPS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("masked_byte_pattern_scanner: assertion failed");

// next-cycle implication
`define MBPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("masked_byte_pattern_scanner: assertion failed");

`endif

// ===== src/mbps_pkg.sv =====
// shared types and constants of the masked byte pattern scanner
// no dependencies
`default_nettype none

package mbps_pkg;

  localparam int unsigned PATTERN_MAX   = 32;
  localparam int unsigned POSITION_BITS = 32;
  localparam int unsigned COUNT_BITS    = 16;

  localparam int unsigned LEN_W     = 6;
  localparam int unsigned WIN_IDX_W = $clog2(PATTERN_MAX);
  localparam int unsigned PAT_WORDS = 4;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MASK_W    = 32;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LEN   = 3'd0,
    REG_PATTERN_LO    = 3'd1,
    REG_PATTERN_MID   = 3'd2,
    REG_PATTERN_UPPER = 3'd3,
    REG_PATTERN_TOP   = 3'd4,
    REG_CARE_MASK     = 3'd5,
    REG_MAX_MATCHES   = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    KIND_HIT     = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_e;

  // results caused by one byte: an optional hit and an optional summary
  typedef struct packed {
    logic                     has_hit;
    logic                     has_sum;
    logic [POSITION_BITS-1:0] offset;
    logic [COUNT_BITS-1:0]    count;
    logic                     ovf;
  } scan_rec_t;

endpackage

`default_nettype wire

// ===== src/masked_byte_pattern_scanner.sv =====
// Masked byte pattern scanner: takes one byte per cycle (a transfer every clock
// when the output keeps up) and checks the window ending at that byte against a
// pattern of up to 32 bytes with per-byte wildcards, in one registered pass: the
// compare and all stream state update happen in the cycle the byte is taken, and
// the results land in a two-entry result queue. Each result leaves in its own
// output transfer, so a byte that causes both a hit and the end-of-stream summary
// needs two output transfers; input is taken while the queue has room.
// Depends on mbps_pkg and masked_byte_pattern_scanner_assert.svh.
`default_nettype none

module masked_byte_pattern_scanner (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // configuration writes
  input  wire logic                                   cfg_we_i,
  input  wire logic [mbps_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [mbps_pkg::CFG_W-1:0]             cfg_data_i,
  // byte stream in
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  input  wire logic [mbps_pkg::IN_DATA_W-1:0]         s_axis_tdata,  // data_byte
  input  wire logic                                   s_axis_tlast,  // last_byte
  // results out
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // hit_offset[31:0], match_count[47:32], position_overflow[48], zero pad
  output logic [mbps_pkg::OUT_DATA_W-1:0]             m_axis_tdata,
  output logic                                        m_axis_tuser,  // result_kind
  output logic                                        m_axis_tlast   // last_result
);

  `include "masked_byte_pattern_scanner_assert.svh"

  localparam int unsigned PM  = mbps_pkg::PATTERN_MAX;
  localparam int unsigned PB  = mbps_pkg::POSITION_BITS;
  localparam int unsigned CB  = mbps_pkg::COUNT_BITS;
  localparam int unsigned LW  = mbps_pkg::LEN_W;
  localparam int unsigned IW  = mbps_pkg::WIN_IDX_W;

  // configuration registers
  logic [LW-1:0]                                    len_q;
  logic [mbps_pkg::PAT_WORDS-1:0][mbps_pkg::CFG_W-1:0] pat_q;
  logic [mbps_pkg::MASK_W-1:0]                      care_q;
  logic [mbps_pkg::LIMIT_W-1:0]                     max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      pat_q  <= '0;
      care_q <= '0;
      max_q  <= mbps_pkg::LIMIT_W'(1);
    end else if (cfg_we_i) begin
      unique case (mbps_pkg::cfg_reg_e'(cfg_index_i))
        mbps_pkg::REG_PATTERN_LEN:   len_q    <= cfg_data_i[LW-1:0];
        mbps_pkg::REG_PATTERN_LO:    pat_q[0] <= cfg_data_i;
        mbps_pkg::REG_PATTERN_MID:   pat_q[1] <= cfg_data_i;
        mbps_pkg::REG_PATTERN_UPPER: pat_q[2] <= cfg_data_i;
        mbps_pkg::REG_PATTERN_TOP:   pat_q[3] <= cfg_data_i;
        mbps_pkg::REG_CARE_MASK:     care_q   <= cfg_data_i[mbps_pkg::MASK_W-1:0];
        mbps_pkg::REG_MAX_MATCHES:   max_q    <= cfg_data_i[mbps_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // stream state
  logic [PM-1:0][7:0] win_q, win_d;
  logic [PB-1:0]      pos_q, pos_d;
  logic [CB-1:0]      hits_q, hits_d;
  logic               lim_q, lim_d;
  logic               ovf_q, ovf_d;

  logic               in_acc;
  logic [PM-1:0][7:0] win_shift;
  logic [LW-1:0]      n_len;
  logic [PM-1:0]      len_mask;
  logic [PM-1:0]      byte_ok;
  logic               care_any;
  logic               pos_at_max;
  logic               ovf_now;
  logic               lim_pre;
  logic               enough;
  logic               hit;
  logic [CB-1:0]      hits_inc;
  logic               lim_post;
  mbps_pkg::scan_rec_t rec_new;
  logic               push;

  assign in_acc     = s_axis_tvalid & s_axis_tready;
  assign win_shift  = {win_q[PM-2:0], s_axis_tdata};
  assign n_len      = (len_q > LW'(PM)) ? LW'(PM) : len_q;
  assign pos_at_max = (pos_q == {PB{1'b1}});
  assign ovf_now    = ovf_q | pos_at_max;
  assign lim_pre    = lim_q | (CB'(hits_q) >= CB'(max_q)) | (hits_q == {CB{1'b1}});
  assign enough     = ({1'b0, pos_q} + (PB+1)'(1)) >= (PB+1)'(n_len);

  // per pattern byte compare against the tap it lines up with
  always_comb begin
    logic [LW-1:0] tap;
    for (int i = 0; i < PM; i++) begin
      tap         = LW'(n_len - LW'(i) - LW'(1));
      len_mask[i] = (LW'(i) < n_len);
      byte_ok[i]  = !(len_mask[i] & care_q[i]) ||
                    (win_shift[tap[IW-1:0]] == pat_q[i / 8][(i % 8) * 8 +: 8]);
    end
  end

  assign care_any = |(care_q & len_mask);
  assign hit = (n_len != '0) & !ovf_now & !lim_pre & enough & care_any & (&byte_ok);
  assign hits_inc = hits_q + CB'(hit);
  assign lim_post = lim_pre |
                    (hit & ((CB'(hits_inc) >= CB'(max_q)) | (hits_inc == {CB{1'b1}})));

  always_comb begin
    rec_new.has_hit = hit;
    rec_new.has_sum = s_axis_tlast;
    rec_new.offset  = PB'(pos_q + PB'(1) - PB'(n_len));
    rec_new.count   = hits_inc;
    rec_new.ovf     = ovf_now;
  end

  assign push = in_acc & (hit | s_axis_tlast);

  always_comb begin
    win_d  = win_q;
    pos_d  = pos_q;
    hits_d = hits_q;
    lim_d  = lim_q;
    ovf_d  = ovf_q;
    if (in_acc) begin
      if (s_axis_tlast) begin
        // end of stream: back to a fresh stream
        win_d  = '0;
        pos_d  = '0;
        hits_d = '0;
        lim_d  = 1'b0;
        ovf_d  = 1'b0;
      end else begin
        win_d  = win_shift;
        pos_d  = pos_at_max ? pos_q : pos_q + PB'(1);
        hits_d = hits_inc;
        lim_d  = lim_post;
        ovf_d  = ovf_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      pos_q  <= '0;
      hits_q <= '0;
      lim_q  <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      win_q  <= win_d;
      pos_q  <= pos_d;
      hits_q <= hits_d;
      lim_q  <= lim_d;
      ovf_q  <= ovf_d;
    end
  end

  // two-entry result queue
  mbps_pkg::scan_rec_t rec_q [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                hit_sent_q, hit_sent_d;
  mbps_pkg::scan_rec_t head;
  logic                show_hit;
  logic                out_acc;
  logic                pop;

  assign head          = rec_q[rd_ptr_q];
  assign s_axis_tready = (cnt_q != 2'd2);
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign show_hit      = head.has_hit & !hit_sent_q;
  assign out_acc       = m_axis_tvalid & m_axis_tready;
  assign pop           = out_acc & !(show_hit & head.has_sum);

  assign m_axis_tuser = show_hit ? mbps_pkg::KIND_HIT : mbps_pkg::KIND_SUMMARY;
  assign m_axis_tlast = show_hit ? !head.has_sum : 1'b1;
  assign m_axis_tdata = {7'b0, head.ovf, head.count,
                         (show_hit ? head.offset : {PB{1'b0}})};

  always_comb begin
    wr_ptr_d   = wr_ptr_q ^ push;
    rd_ptr_d   = rd_ptr_q ^ pop;
    cnt_d      = cnt_q + 2'(push) - 2'(pop);
    hit_sent_d = hit_sent_q;
    if (pop) begin
      hit_sent_d = 1'b0;
    end else if (out_acc) begin
      // hit went out, summary of the same byte still waits
      hit_sent_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      rec_q[wr_ptr_q] <= rec_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      cnt_q      <= 2'd0;
      hit_sent_q <= 1'b0;
    end else begin
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
      hit_sent_q <= hit_sent_d;
    end
  end

  `MBPS_ASSERT(a_no_queue_overrun, push, cnt_q != 2'd2)
  `MBPS_ASSERT(a_no_hit_after_overflow, push && rec_new.has_hit, !rec_new.ovf)
  `MBPS_ASSERT(a_hit_last_flag, m_axis_tvalid && show_hit, m_axis_tlast == !head.has_sum)
  `MBPS_ASSERT_NEXT(a_stream_cleared, in_acc && s_axis_tlast,
                    pos_q == '0 && hits_q == '0 && !ovf_q && !lim_q)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// self-checking testbench for masked_byte_pattern_scanner: a byte stream driver, a result
// monitor and a cycle-free scanner predictor that builds the expected hit/summary transfers
// depends on mbps_pkg and the scanner rtl
`timescale 1ns / 100ps

module tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_BYTES = 900;
  localparam int CALM_FROM = 780;

  typedef struct {
    logic [7:0] data;
    logic       ends;
  } stream_byte_t;

  typedef struct {
    mbps_pkg::result_kind_e             kind;
    logic [mbps_pkg::POSITION_BITS-1:0] offset;
    logic [mbps_pkg::COUNT_BITS-1:0]    count;
    logic                               ovf;
    logic                               lastr;
  } scan_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [mbps_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [mbps_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [mbps_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  masked_byte_pattern_scanner i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // shadow of the scanner registers, reset values
  logic [mbps_pkg::LEN_W-1:0]   pat_len = '0;
  logic [mbps_pkg::CFG_W-1:0]   pattern_words [mbps_pkg::PAT_WORDS] = '{default: '0};
  logic [mbps_pkg::MASK_W-1:0]  care_bits = '0;
  logic [mbps_pkg::LIMIT_W-1:0] hit_limit = 16'd1;

  // predicted stream state
  logic [7:0]                         scan_window [mbps_pkg::PATTERN_MAX] = '{default: '0};
  logic [mbps_pkg::POSITION_BITS-1:0] stream_pos = '0;
  logic [mbps_pkg::COUNT_BITS-1:0]    hits_found = '0;
  logic                               limit_hit = 1'b0;
  logic                               ovf_seen = 1'b0;

  stream_byte_t bytes_to_send [$];
  scan_report_t pending_reports [$];
  stream_byte_t send_item;
  scan_report_t want_report;

  int send_gap = 0;
  int recv_stall = 0;
  int send_gap_odds = 0;
  int recv_stall_odds = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int random_sent = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] pat_byte(int i);
    return pattern_words[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic logic [7:0] rand_byte(bit narrow);
    return narrow ? 8'h41 + 8'($urandom_range(0, 1)) : 8'($urandom);
  endfunction

  // advance the predicted scanner by one byte and queue what it reports
  task automatic scan_byte(input logic [7:0] b, input logic ends);
    logic [mbps_pkg::POSITION_BITS-1:0] idx;
    int unsigned n;
    int k;
    bit some_fixed;
    bit all_agree;
    idx = stream_pos;
    for (k = mbps_pkg::PATTERN_MAX - 1; k > 0; k--) scan_window[k] = scan_window[k - 1];
    scan_window[0] = b;
    if (stream_pos == '1) ovf_seen = 1'b1;
    else stream_pos++;
    if (hits_found >= hit_limit || hits_found == '1) limit_hit = 1'b1;
    n = (pat_len > mbps_pkg::PATTERN_MAX) ? mbps_pkg::PATTERN_MAX : pat_len;
    if (n > 0 && !ovf_seen && !limit_hit && (64'(idx) + 1 >= 64'(n))) begin
      some_fixed = 1'b0;
      all_agree = 1'b1;
      for (k = 0; k < n; k++) begin
        if (care_bits[k]) begin
          some_fixed = 1'b1;
          if (scan_window[n - 1 - k] != pat_byte(k)) all_agree = 1'b0;
        end
      end
      if (some_fixed && all_agree) begin
        hits_found++;
        if (hits_found >= hit_limit || hits_found == '1) limit_hit = 1'b1;
        pending_reports.insert(pending_reports.size(),
                               '{mbps_pkg::KIND_HIT, idx + 1 - n, hits_found, ovf_seen, !ends});
      end
    end
    if (ends) begin
      pending_reports.insert(pending_reports.size(),
                             '{mbps_pkg::KIND_SUMMARY, '0, hits_found, ovf_seen, 1'b1});
      for (k = 0; k < mbps_pkg::PATTERN_MAX; k++) scan_window[k] = '0;
      stream_pos = '0;
      hits_found = '0;
      limit_hit = 1'b0;
      ovf_seen = 1'b0;
    end
  endtask

  // byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) scan_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (bytes_to_send.size() != 0 && send_gap_odds != 0 &&
                     $urandom_range(0, send_gap_odds - 1) == 0) begin
          send_gap = $urandom_range(0, 12);
          s_axis_tvalid <= 1'b0;
        end else if (bytes_to_send.size() != 0) begin
          send_item = bytes_to_send.pop_front();
          s_axis_tdata <= send_item.data;
          s_axis_tlast <= send_item.ends;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected transfer, expected none actual kind %0d data %0h last %0d",
                   $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want_report = pending_reports.pop_front();
          check_field("result kind", want_report.kind, m_axis_tuser);
          check_field("hit offset", want_report.offset, m_axis_tdata[31:0]);
          check_field("match count", want_report.count, m_axis_tdata[47:32]);
          check_field("position overflow", want_report.ovf, m_axis_tdata[48]);
          check_field("tdata pad", '0, m_axis_tdata[mbps_pkg::OUT_DATA_W-1:49]);
          check_field("last result", want_report.lastr, m_axis_tlast);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else if (recv_stall_odds != 0 && $urandom_range(0, recv_stall_odds - 1) == 0) begin
        recv_stall = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL masked_byte_pattern_scanner");
      $finish;
    end
  end

  task automatic write_reg(input mbps_pkg::cfg_reg_e which,
                           input logic [mbps_pkg::CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i <= value;
    case (which)
      mbps_pkg::REG_PATTERN_LEN:   pat_len = value[mbps_pkg::LEN_W-1:0];
      mbps_pkg::REG_PATTERN_LO:    pattern_words[0] = value;
      mbps_pkg::REG_PATTERN_MID:   pattern_words[1] = value;
      mbps_pkg::REG_PATTERN_UPPER: pattern_words[2] = value;
      mbps_pkg::REG_PATTERN_TOP:   pattern_words[3] = value;
      mbps_pkg::REG_CARE_MASK:     care_bits = value[mbps_pkg::MASK_W-1:0];
      mbps_pkg::REG_MAX_MATCHES:   hit_limit = value[mbps_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // junk above a register's width must be dropped by the block
  task automatic program_scanner(input logic [mbps_pkg::LEN_W-1:0] len,
                                 input logic [mbps_pkg::CFG_W-1:0] w0,
                                 input logic [mbps_pkg::CFG_W-1:0] w1,
                                 input logic [mbps_pkg::CFG_W-1:0] w2,
                                 input logic [mbps_pkg::CFG_W-1:0] w3,
                                 input logic [mbps_pkg::MASK_W-1:0] care,
                                 input logic [mbps_pkg::LIMIT_W-1:0] limit, input bit junk);
    logic [mbps_pkg::CFG_W-1:0] upper;
    upper = junk ? {$urandom, $urandom} : '0;
    write_reg(mbps_pkg::REG_PATTERN_LEN, {upper[mbps_pkg::CFG_W-1:mbps_pkg::LEN_W], len});
    write_reg(mbps_pkg::REG_PATTERN_LO, w0);
    write_reg(mbps_pkg::REG_PATTERN_MID, w1);
    write_reg(mbps_pkg::REG_PATTERN_UPPER, w2);
    write_reg(mbps_pkg::REG_PATTERN_TOP, w3);
    write_reg(mbps_pkg::REG_CARE_MASK, {upper[mbps_pkg::CFG_W-1:mbps_pkg::MASK_W], care});
    write_reg(mbps_pkg::REG_MAX_MATCHES, {upper[mbps_pkg::CFG_W-1:mbps_pkg::LIMIT_W], limit});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_run(input logic [7:0] vals[$]);
    foreach (vals[i])
      bytes_to_send.insert(bytes_to_send.size(), '{vals[i], i == vals.size() - 1});
  endtask

  // random stream with planted pattern copies, some of them cut short
  task automatic add_stream(input int target_len, input bit narrow);
    logic [7:0] run [$];
    int n;
    int m;
    int i;
    n = (pat_len > mbps_pkg::PATTERN_MAX) ? mbps_pkg::PATTERN_MAX : pat_len;
    while (run.size() < target_len) begin
      if (n > 0 && $urandom_range(0, 2) == 0) begin
        m = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
        for (i = 0; i < m; i++)
          run.insert(run.size(), care_bits[i] ? pat_byte(i) : rand_byte(narrow));
      end else begin
        run.insert(run.size(), rand_byte(narrow));
      end
    end
    add_run(run);
    random_sent += run.size();
  endtask

  // block drained: wait until no byte or result is outstanding before touching registers
  task automatic wait_idle();
    do @(negedge clk_i);
    while (bytes_to_send.size() != 0 || s_axis_tvalid || pending_reports.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic int pick_odds();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
  endfunction

  initial begin
    logic [mbps_pkg::LEN_W-1:0]   len;
    logic [mbps_pkg::CFG_W-1:0]   words [mbps_pkg::PAT_WORDS];
    logic [mbps_pkg::MASK_W-1:0]  care;
    logic [mbps_pkg::LIMIT_W-1:0] limit;
    bit narrow;
    int phase_target;
    int phase_start;
    int phase;
    int i;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_gap_odds = pick_odds();
    recv_stall_odds = pick_odds();

    // reset config: zero length, summaries only
    add_run('{8'h00, 8'hFF});
    wait_idle();

    // fixed AA BB, wildcard, DD; short stream, then two hits, the second on the last byte
    program_scanner(6'd4, 64'hFFFF_FFFF_DD77_BBAA, '1, '1, '1, 32'hFFFF_FFFB, 16'hFFFF, 1'b0);
    add_run('{8'hAA});
    add_run('{8'hAA, 8'hBB, 8'h55, 8'hDD, 8'hAA, 8'hBB, 8'h12, 8'hDD});
    wait_idle();
    // zero limit
    program_scanner(6'd4, 64'hFFFF_FFFF_DD77_BBAA, '1, '1, '1, 32'hFFFF_FFFB, 16'd0, 1'b0);
    add_run('{8'hAA, 8'hBB, 8'h00, 8'hDD});
    wait_idle();
    // all-wildcard pattern
    program_scanner(6'd1, '0, '0, '0, '0, 32'd0, 16'd2, 1'b0);
    add_run('{8'h00, 8'hFF, 8'h00});
    wait_idle();
    // back-to-back hits cut by the limit
    program_scanner(6'd1, '0, '0, '0, '0, 32'd1, 16'd2, 1'b0);
    add_run('{8'h00, 8'h00, 8'h00});
    wait_idle();

    phase = 0;
    while (random_sent < RANDOM_BYTES) begin
      if (random_sent >= CALM_FROM) begin
        send_gap_odds = 0;
        recv_stall_odds = 0;
      end else begin
        send_gap_odds = pick_odds();
        recv_stall_odds = pick_odds();
      end
      narrow = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: len = 6'd0;
        1: len = 6'd32;
        2: len = 6'($urandom_range(33, 63));
        3, 4: len = 6'($urandom_range(9, 31));
        default: len = 6'($urandom_range(1, 8));
      endcase
      if (phase == 0) len = 6'd63;
      if (phase == 1) len = 6'd32;
      if (narrow && phase > 1) len = 6'($urandom_range(1, 4));
      for (i = 0; i < mbps_pkg::PAT_WORDS; i++) begin
        case ($urandom_range(0, 7))
          0: words[i] = '0;
          1: words[i] = '1;
          default: words[i] = {$urandom, $urandom};
        endcase
      end
      if (narrow) begin
        for (i = 0; i < mbps_pkg::PATTERN_MAX; i++)
          words[i / 8][(i % 8) * 8 +: 8] = rand_byte(1'b1);
      end
      case ($urandom_range(0, 7))
        0: care = '0;
        1: care = '1;
        2: care = $urandom & $urandom;
        default: care = $urandom;
      endcase
      if (phase < 2) care = '1;
      case ($urandom_range(0, 7))
        0: limit = '0;
        1: limit = '1;
        2, 3: limit = 16'($urandom_range(1, 3));
        default: limit = 16'($urandom_range(4, 100));
      endcase
      program_scanner(len, words[0], words[1], words[2], words[3], care, limit,
                      $urandom_range(0, 1));
      phase_target = $urandom_range(20, 45);
      phase_start = random_sent;
      while (random_sent - phase_start < phase_target)
        add_stream(($urandom_range(0, 4) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 12),
                   narrow);
      wait_idle();
      phase++;
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("PASS masked_byte_pattern_scanner");
    end else begin
      $display("FAIL masked_byte_pattern_scanner");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/mbps_pkg.sv
src/masked_byte_pattern_scanner.sv
dv/tb.sv
